### design/i2cbw_pkg.sv
// Shared types and constants of the I2C write master.
// No dependencies; imported by every module of the block.
package i2cbw_pkg;

  localparam int unsigned HOLD_W              = 16;
  localparam int unsigned HOLD_COUNT_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  localparam logic [7:0]        DEV_ADDR_RST   = 8'h00;
  localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = 16'd120;
  localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = 16'd240;

  localparam logic [1:0] REG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] REG_SHORT_HOLD = 2'd1;
  localparam logic [1:0] REG_LONG_HOLD  = 2'd2;

  typedef struct packed {
    logic       stop;
    logic       start;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic              last;
    logic [HOLD_W-1:0] hold;
    logic              sda;
    logic              scl;
  } event_t;

  typedef struct packed {
    logic [7:0]        dev_addr;
    logic [HOLD_W-1:0] short_hold;
    logic [HOLD_W-1:0] long_hold;
  } cfg_t;

endpackage

### design/i2cbw_front.sv
// Intake stage: registers one input word and classifies it into a command.
// Depends on i2cbw_pkg.
module i2cbw_front import i2cbw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_start_i,
  input  logic       in_stop_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= '{stop: in_stop_i, start: in_start_i, data: in_data_i};
    end
  end

endmodule

### design/i2cbw_fifo.sv
// Short command queue between the intake stage and the event sequencer.
// Depends on i2cbw_pkg.
module i2cbw_fifo import i2cbw_pkg::*; #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic [CntW-1:0]  count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign count_o      = cnt_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### design/i2cbw_seq.sv
// Event sequencer: walks start, address, data, ack and stop phases into a
// registered output, one pin event per cycle unless stalled. Depends on i2cbw_pkg.
module i2cbw_seq import i2cbw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   cmd_valid_i,
  output logic   cmd_pop_o,
  input  cmd_t   cmd_i,
  output logic   ev_valid_o,
  input  logic   ev_ready_i,
  output event_t ev_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START_SDA,
    PH_START_SCL,
    PH_BIT,
    PH_STOP_SETUP,
    PH_STOP_SCL,
    PH_STOP_SDA_LO,
    PH_STOP_SDA_HI
  } phase_e;

  localparam logic [3:0] BitLast = 4'd7;
  localparam logic [3:0] BitAck  = 4'd8;

  phase_e     phase_q, phase_d;
  logic [7:0] byte_q, byte_d, data_q, data_d;
  logic       stop_q, stop_d, addr_q, addr_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] step_q, step_d;
  logic       scl_q, sda_q;
  logic       ev_valid_q, ev_valid_d;
  event_t     ev_q, ev;
  logic       advance, pop;

  assign advance    = (phase_q != PH_IDLE) && (!ev_valid_q || ev_ready_i);
  assign pop        = cmd_valid_i && ((phase_q == PH_IDLE) || (advance && ev.last));
  assign cmd_pop_o  = pop;
  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

  always_comb begin
    ev      = '{last: 1'b0, hold: '0, sda: sda_q, scl: scl_q};
    phase_d = phase_q;
    byte_d  = byte_q;
    data_d  = data_q;
    stop_d  = stop_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    unique case (phase_q)
      PH_START_SDA: begin
        ev.sda  = 1'b0;
        ev.hold = cfg_i.short_hold;
        phase_d = PH_START_SCL;
      end
      PH_START_SCL: begin
        ev.scl  = 1'b0;
        ev.hold = cfg_i.short_hold;
        phase_d = PH_BIT;
      end
      PH_BIT: begin
        if (cnt_q == BitAck) begin
          if (step_q == 2'd2) begin
            ev.scl = 1'b0;
            if (addr_q) begin
              byte_d = data_q;
              addr_d = 1'b0;
              cnt_d  = '0;
              step_d = 2'd0;
            end else if (stop_q) begin
              phase_d = PH_STOP_SETUP;
            end else begin
              ev.last = 1'b1;
              phase_d = PH_IDLE;
            end
          end else begin
            ev.scl  = 1'b1;
            ev.hold = cfg_i.long_hold;
            step_d  = 2'd2;
          end
        end else begin
          unique case (step_q)
            2'd1: begin
              ev.scl  = 1'b1;
              ev.hold = cfg_i.long_hold;
              step_d  = 2'd2;
            end
            2'd2: begin
              ev.scl  = 1'b0;
              ev.hold = (cnt_q == BitLast) ? cfg_i.long_hold : '0;
              byte_d  = {byte_q[6:0], 1'b0};
              cnt_d   = cnt_q + 4'd1;
              step_d  = (cnt_q == BitLast) ? 2'd1 : 2'd0;
            end
            default: begin
              ev.sda  = byte_q[7];
              ev.hold = cfg_i.long_hold;
              step_d  = 2'd1;
            end
          endcase
        end
      end
      PH_STOP_SETUP: begin
        ev.hold = cfg_i.short_hold;
        phase_d = PH_STOP_SCL;
      end
      PH_STOP_SCL: begin
        ev.scl  = 1'b1;
        phase_d = PH_STOP_SDA_LO;
      end
      PH_STOP_SDA_LO: begin
        ev.scl  = 1'b1;
        ev.sda  = 1'b0;
        ev.hold = cfg_i.short_hold;
        phase_d = PH_STOP_SDA_HI;
      end
      PH_STOP_SDA_HI: begin
        ev.scl  = 1'b1;
        ev.sda  = 1'b1;
        ev.hold = cfg_i.long_hold;
        ev.last = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
      end
    endcase
    if (pop) begin
      phase_d = cmd_i.start ? PH_START_SDA : PH_BIT;
      byte_d  = cmd_i.start ? cfg_i.dev_addr : cmd_i.data;
      data_d  = cmd_i.data;
      stop_d  = cmd_i.stop;
      addr_d  = cmd_i.start;
      cnt_d   = '0;
      step_d  = 2'd0;
    end
  end

  always_comb begin
    ev_valid_d = ev_valid_q;
    if (advance) begin
      ev_valid_d = 1'b1;
    end else if (ev_ready_i) begin
      ev_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      ev_valid_q <= 1'b0;
    end else begin
      ev_valid_q <= ev_valid_d;
      if (advance || pop) begin
        phase_q <= phase_d;
      end
      if (advance) begin
        scl_q <= ev.scl;
        sda_q <= ev.sda;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance || pop) begin
      byte_q <= byte_d;
      data_q <= data_d;
      stop_q <= stop_d;
      addr_q <= addr_d;
      cnt_q  <= cnt_d;
      step_q <= step_d;
    end
    if (advance) begin
      ev_q <= ev;
    end
  end

endmodule

### design/i2c_bitbang_write_master_top.sv
// Top level of the I2C write master: register port, intake, queue, sequencer.
// Depends on i2cbw_pkg, i2cbw_front, i2cbw_fifo and i2cbw_seq.
//
// Usage: each input word (s_axis) carries one byte in tdata and the start and
// stop flags in tuser. The block answers on m_axis with a run of pin events,
// each giving SCL and SDA levels and the ticks to hold them; tlast marks the
// final event of the word. A plain byte gives 26 events, a start adds 28 more
// (start pair plus address byte), a stop adds 4, so at most 58 events.
// The sequencer issues one event per cycle while m_axis is not stalled.
// Words queue in the intake register and a short command queue while the
// sequencer works, and the next word's first event follows the previous
// last event directly. A word accepted into an empty block passes the intake
// register, the queue, the sequencer phase register and the event register
// before its first event appears. A stalled m_axis holds the current event
// and the sequencer; s_axis keeps taking words until queue and intake fill.
// Reset sets both bus lines idle high, empties the queue and loads the
// register defaults (address 0, short hold 120, long hold 240).
// Registers are written over APB at byte addresses 0, 4 and 8.
module i2c_bitbang_write_master_top import i2cbw_pkg::*; #(
  parameter int unsigned HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [1:0]  s_axis_tuser,   // with_start, with_stop
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // scl_level, sda_level, hold_ticks[15:0], zero pad
  output logic        m_axis_tlast
);

  localparam logic [32:0] HoldMax = (33'd1 << HOLD_COUNT_BITS) - 33'd1;
  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [HOLD_W-1:0] sat_hold(input logic [HOLD_W-1:0] v);
    logic [32:0] wide;
    wide = {{(33 - HOLD_W){1'b0}}, v};
    return (wide > HoldMax) ? HoldMax[HOLD_W-1:0] : v;
  endfunction

  logic [7:0]        dev_addr_q;
  logic [HOLD_W-1:0] short_hold_q, long_hold_q;
  logic              wr_en;
  cfg_t              cfg;

  logic              front_valid, front_ready;
  cmd_t              front_cmd;
  logic              q_valid, q_pop;
  logic [$bits(cmd_t)-1:0] q_data;
  logic [CntW-1:0]   q_count;
  event_t            ev;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= DEV_ADDR_RST;
      short_hold_q <= SHORT_HOLD_RST;
      long_hold_q  <= LONG_HOLD_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DEV_ADDR:   dev_addr_q   <= pwdata[7:0];
        REG_SHORT_HOLD: short_hold_q <= pwdata[HOLD_W-1:0];
        REG_LONG_HOLD:  long_hold_q  <= pwdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEV_ADDR:   prdata = {24'd0, dev_addr_q};
      REG_SHORT_HOLD: prdata = {{(32 - HOLD_W){1'b0}}, short_hold_q};
      REG_LONG_HOLD:  prdata = {{(32 - HOLD_W){1'b0}}, long_hold_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg = '{dev_addr:   dev_addr_q,
                 short_hold: sat_hold(short_hold_q),
                 long_hold:  sat_hold(long_hold_q)};

  i2cbw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser[0]),
    .in_stop_i   (s_axis_tuser[1]),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  i2cbw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data),
    .count_o      (q_count)
  );

  i2cbw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (cmd_t'(q_data)),
    .ev_valid_o  (m_axis_tvalid),
    .ev_ready_i  (m_axis_tready),
    .ev_o        (ev)
  );

  assign m_axis_tdata = {6'd0, ev.hold, ev.sda, ev.scl};
  assign m_axis_tlast = ev.last;

  a_last_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tdata[1:0] == 2'b11) ||
      (!m_axis_tdata[0] && (m_axis_tdata[17:2] == 16'd0)))
    else $error("final event is neither a stop nor an ack clock low");

  a_hold_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({17'd0, m_axis_tdata[17:2]} <= HoldMax))
    else $error("hold ticks exceed hold counter range");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("sequencer took a command from an empty queue");

endmodule

### test/i2c_bitbang_write_master_top_tb.sv
// Self-checking testbench for i2c_bitbang_write_master_top: drives byte words and
// register writes, predicts every pin event and compares each one as it comes out.
// Depends on i2cbw_pkg and the design sources of the block.
module i2c_bitbang_write_master_top_tb import i2cbw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT   = 3000;
  localparam int         PHASE_ITEMS  = 58;
  localparam int         HOLD_OFF_AT  = 800;
  localparam int         HOLD_OFF_LEN = 400;

  class pin_event_scoreboard;
    logic [7:0]        dev_addr;
    logic [HOLD_W-1:0] short_ticks;
    logic [HOLD_W-1:0] long_ticks;
    bit                sda_now;
    bit                scl_now;
    event_t            events_due[$];
    int                errors;

    function new();
      dev_addr    = DEV_ADDR_RST;
      short_ticks = SHORT_HOLD_RST;
      long_ticks  = LONG_HOLD_RST;
      sda_now     = 1'b1;
      scl_now     = 1'b1;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_DEV_ADDR:   dev_addr    = value[7:0];
        REG_SHORT_HOLD: short_ticks = value[HOLD_W-1:0];
        REG_LONG_HOLD:  long_ticks  = value[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_pin(bit scl, bit sda, logic [HOLD_W-1:0] ticks);
      event_t ev;
      scl_now = scl;
      sda_now = sda;
      ev.scl  = scl;
      ev.sda  = sda;
      ev.hold = ticks;
      ev.last = 1'b0;
      events_due.push_back(ev);
    endfunction

    function void push_byte(logic [7:0] b);
      for (int i = 7; i >= 0; i--) begin
        push_pin(scl_now, b[i], long_ticks);
        push_pin(1'b1, sda_now, long_ticks);
        push_pin(1'b0, sda_now, (i == 0) ? long_ticks : '0);
      end
      push_pin(1'b1, sda_now, long_ticks);
      push_pin(1'b0, sda_now, '0);
    endfunction

    function void note_word(cmd_t c);
      if (c.start) begin
        push_pin(scl_now, 1'b0, short_ticks);
        push_pin(1'b0, sda_now, short_ticks);
        push_byte(dev_addr);
      end
      push_byte(c.data);
      if (c.stop) begin
        push_pin(scl_now, sda_now, short_ticks);
        push_pin(1'b1, sda_now, '0);
        push_pin(1'b1, 1'b0, short_ticks);
        push_pin(1'b1, 1'b1, long_ticks);
      end
      events_due[events_due.size()-1].last = 1'b1;
    endfunction

    function void check_event(logic [23:0] tdata, logic tlast);
      event_t exp;
      logic [HOLD_W-1:0] got_hold;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event tdata=%0h tlast=%0b", $time, tdata, tlast);
        errors++;
        return;
      end
      exp      = events_due.pop_front();
      got_hold = tdata[2 +: HOLD_W];
      if (tdata[0] !== exp.scl) begin
        $display("%0t: scl expected %0b actual %0b", $time, exp.scl, tdata[0]);
        errors++;
      end
      if (tdata[1] !== exp.sda) begin
        $display("%0t: sda expected %0b actual %0b", $time, exp.sda, tdata[1]);
        errors++;
      end
      if (got_hold !== exp.hold) begin
        $display("%0t: hold expected %0d actual %0d", $time, exp.hold, got_hold);
        errors++;
      end
      if (tlast !== exp.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp.last, tlast);
        errors++;
      end
    endfunction

    function int pending();
      return events_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic [1:0]  s_axis_tuser;   // with_start, with_stop
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // scl_level, sda_level, hold_ticks[15:0], zero pad
  logic        m_axis_tlast;

  pin_event_scoreboard sb;
  bit src_calm;
  bit sink_calm;
  bit held_off;
  int events_seen;

  i2c_bitbang_write_master_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_word(cmd_t c);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c.data;
    s_axis_tuser  <= {c.stop, c.start};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(c);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_hold();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 16'd1;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic cmd_t make_word(logic [7:0] data, bit start, bit stop);
    cmd_t c;
    c.data  = data;
    c.start = start;
    c.stop  = stop;
    return c;
  endfunction

  initial begin : event_sink
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && events_seen >= HOLD_OFF_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk_i);
        held_off = 1'b1;
      end
      gap = sink_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_event(m_axis_tdata, m_axis_tlast);
      events_seen++;
      if (events_seen % 100 == 0) sink_calm = ~sink_calm;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int   sent;
    int   len;
    cmd_t c;
    sb            = new();
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    held_off      = 1'b0;
    events_seen   = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults; a start right after a byte without stop finds SCL low
    send_word(make_word(8'h00, 1'b1, 1'b0));
    send_word(make_word(8'hFF, 1'b0, 1'b0));
    send_word(make_word(8'hA5, 1'b1, 1'b0));
    send_word(make_word(8'h5A, 1'b0, 1'b1));
    send_word(make_word(8'h00, 1'b1, 1'b1));
    send_word(make_word(8'hFF, 1'b1, 1'b1));
    send_word(make_word(8'h01, 1'b0, 1'b0));
    send_word(make_word(8'h80, 1'b0, 1'b1));
    s_axis_tvalid <= 1'b0;
    drain();

    // zero holds pass through; unmapped register is ignored
    reg_write(REG_DEV_ADDR, 32'h0000_00FF);
    reg_write(REG_SHORT_HOLD, 32'h0000_0000);
    reg_write(REG_LONG_HOLD, 32'h0000_0000);
    reg_write(REG_UNUSED, $urandom());
    send_word(make_word(8'h3C, 1'b1, 1'b1));
    send_word(make_word(8'hC3, 1'b0, 1'b0));
    send_word(make_word(8'h7E, 1'b1, 1'b0));
    send_word(make_word(8'h81, 1'b0, 1'b1));
    s_axis_tvalid <= 1'b0;
    drain();

    reg_write(REG_DEV_ADDR, 32'h0000_0000);
    reg_write(REG_SHORT_HOLD, 32'h0000_FFFF);
    reg_write(REG_LONG_HOLD, 32'h0000_FFFF);
    send_word(make_word(8'hFF, 1'b1, 1'b0));
    send_word(make_word(8'h55, 1'b0, 1'b0));
    send_word(make_word(8'hAA, 1'b0, 1'b1));
    send_word(make_word(8'h0F, 1'b1, 1'b1));
    s_axis_tvalid <= 1'b0;
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      reg_write(REG_DEV_ADDR, $urandom_range(0, 255));
      reg_write(REG_SHORT_HOLD, {16'h0, pick_hold()});
      reg_write(REG_LONG_HOLD, {16'h0, pick_hold()});
      if (phase == 2) reg_write(REG_UNUSED, $urandom());
      src_calm = (phase % 2 == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          c = make_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
          send_word(c);
          sent++;
        end else begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            send_word(make_word(8'($urandom_range(0, 255)), k == 0, k == len - 1));
            sent++;
          end
        end
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
